FILE: rtl/bbt_pkg.sv
// bbt_pkg: types, sizes and pseudo-LRU tree functions of the banked target table
// used by bbt_way_sel and banked_branch_target_table_unit; depends on nothing

package bbt_pkg;

  localparam int WAYS            = 4;
  localparam int BANKS           = 2;
  localparam int SETS            = 64;
  localparam int FETCH_HALFWORDS = 16;

  localparam int BANK_SPAN = (FETCH_HALFWORDS / BANKS) < 1 ? 1 : (FETCH_HALFWORDS / BANKS);
  localparam int ROWS      = BANKS * SETS;

  localparam int BANK_W = BANKS > 1 ? $clog2(BANKS) : 1;
  localparam int SET_W  = SETS > 1 ? $clog2(SETS) : 1;
  localparam int ROW_W  = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int WAY_W  = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int PLRU_W = WAYS > 1 ? WAYS - 1 : 1;
  localparam int LVLS   = WAYS > 1 ? $clog2(WAYS) : 0;
  localparam int LEAVES = 1 << LVLS;

  localparam int TAG_W    = 32;
  localparam int ADDR_W   = 64;
  localparam int SHIFT_W  = 6;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PC_SHIFT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_BITS = 1'd1;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] target;
  } way_data_t;

  typedef way_data_t [WAYS-1:0] data_row_t;

  typedef struct packed {
    logic [WAYS-1:0]   valid;
    logic [PLRU_W-1:0] plru;
  } meta_row_t;

  typedef struct packed {
    logic              hit;
    logic [WAY_W-1:0]  way;
    logic [WAYS-1:0]   valid_next;
    logic [PLRU_W-1:0] plru_next;
    logic [ADDR_W-1:0] target;
  } sel_t;

  // every node on the path of the way points away from it
  function automatic logic [PLRU_W-1:0] plru_touch(logic [PLRU_W-1:0] bits,
                                                    logic [WAY_W-1:0] way);
    logic [PLRU_W-1:0] b;
    int node;
    int parent;
    b = bits;
    node = LEAVES + int'(way);
    for (int l = 0; l < LVLS; l++) begin
      parent = node >> 1;
      b[parent-1] = ((node & 1) == 0);
      node = parent;
    end
    return b;
  endfunction

  // walk from the root; a right subtree with no real way is skipped
  function automatic logic [WAY_W-1:0] plru_victim(logic [PLRU_W-1:0] bits);
    int node;
    int child;
    int first;
    node = 1;
    for (int l = 0; l < LVLS; l++) begin
      child = 2 * node + int'(bits[node-1]);
      first = child << (LVLS - l - 1);
      if (first - LEAVES >= WAYS) child = 2 * node;
      node = child;
    end
    return WAY_W'(node - LEAVES);
  endfunction

endpackage

FILE: rtl/bbt_row_ram.sv
// bbt_row_ram: generic single-port-write, single-port-read synchronous ram
// registered read data; no dependencies

module bbt_row_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/bbt_way_sel.sv
// bbt_way_sel: tag compare, way choice and pseudo-LRU update for one table row
// depends on bbt_pkg

module bbt_way_sel (
  input  logic                       mode_i,
  input  logic [bbt_pkg::TAG_W-1:0]  tag_i,
  input  bbt_pkg::meta_row_t         meta_i,
  input  bbt_pkg::data_row_t         data_i,
  output bbt_pkg::sel_t              sel_o
);

  logic                       match;
  logic [bbt_pkg::WAY_W-1:0]  match_way;
  logic                       free;
  logic [bbt_pkg::WAY_W-1:0]  free_way;
  logic [bbt_pkg::WAY_W-1:0]  way;

  always_comb begin
    match     = 1'b0;
    match_way = '0;
    free      = 1'b0;
    free_way  = '0;
    for (int w = bbt_pkg::WAYS - 1; w >= 0; w--) begin
      if (meta_i.valid[w] && data_i[w].tag == tag_i) begin
        match     = 1'b1;
        match_way = bbt_pkg::WAY_W'(w);
      end
      if (!meta_i.valid[w]) begin
        free     = 1'b1;
        free_way = bbt_pkg::WAY_W'(w);
      end
    end

    if (match)        way = match_way;
    else if (free)    way = free_way;
    else              way = bbt_pkg::plru_victim(meta_i.plru);
    if (!mode_i) way = match_way;

    sel_o.hit        = match;
    sel_o.way        = way;
    sel_o.plru_next  = bbt_pkg::plru_touch(meta_i.plru, way);
    sel_o.valid_next = meta_i.valid;
    if (mode_i) sel_o.valid_next[way] = 1'b1;
    sel_o.target     = match ? data_i[match_way].target : '0;
  end

endmodule

FILE: rtl/banked_branch_target_table_unit.sv
// banked_branch_target_table_unit: banked set-associative target table, top level
// depends on bbt_pkg, bbt_row_ram, bbt_way_sel
//
// usage: an item enters on in_valid_i/in_ready_o. mode 0 is a lookup that returns
// one item per bank on out_valid_o/out_ready_i, in probe order from the pc's bank,
// last_o on the final one. mode 1 writes the entry and returns nothing.
// each bank probe is a read of the meta and data rams (ST_READ) followed by
// compare and write-back (ST_EVAL). the read-then-write per row is the limit;
// one item is in work at a time and probes never overlap. the first result is
// registered as the first probe completes its compare.
// a stalled receiver holds the result register; the next probe waits in its
// compare cycle until the register is free. in_ready_o is low while an item is
// in work and does not wait on the output register, so that register can still
// hold a result while a new item enters.
// reset: a clearing pass walks all ROWS (128) meta ram rows, one row a cycle;
// no item is accepted during it. configuration writes are taken at any time.

module banked_branch_target_table_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bbt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bbt_pkg::SHIFT_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic [bbt_pkg::ADDR_W-1:0]     pc_i,
  input  logic [bbt_pkg::ADDR_W-1:0]     target_i,
  input  logic [bbt_pkg::ADDR_W-1:0]     tag_pc_i,
  input  logic                           tag_pc_valid_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0]                     bank_rel_o,
  output logic                           hit_o,
  output logic [bbt_pkg::ADDR_W-1:0]     found_target_o,
  output logic                           last_o
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EVAL  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [bbt_pkg::SHIFT_W-1:0] pc_shift_q;
  logic [bbt_pkg::SHIFT_W-1:0] tag_bits_q;
  logic [bbt_pkg::ROW_W-1:0]   clr_q;
  logic [bbt_pkg::BANK_W-1:0]  off_q;

  logic                        mode_q;
  logic [bbt_pkg::BANK_W-1:0]  bank_q;
  logic [bbt_pkg::SET_W-1:0]   set_q;
  logic [bbt_pkg::SET_W-1:0]   next_set_q;
  logic [bbt_pkg::TAG_W-1:0]   tag_q;
  logic [bbt_pkg::ADDR_W-1:0]  target_q;

  logic                        out_valid_q;
  logic [2:0]                  out_off_q;
  logic                        out_hit_q;
  logic [bbt_pkg::ADDR_W-1:0]  out_target_q;
  logic                        out_last_q;

  // address decode of the incoming item
  logic [bbt_pkg::ADDR_W-1:0]  block_pc;
  logic [bbt_pkg::ADDR_W-1:0]  block_tag;
  logic [bbt_pkg::ADDR_W-1:0]  upper_tag;
  logic [bbt_pkg::SHIFT_W-1:0] tag_w;
  logic [bbt_pkg::TAG_W:0]     tag_mask;
  logic [bbt_pkg::SET_W-1:0]   set_in;

  always_comb begin
    block_pc  = (pc_i >> pc_shift_q) / bbt_pkg::BANK_SPAN;
    block_tag = (((mode_i && tag_pc_valid_i) ? tag_pc_i : pc_i) >> pc_shift_q)
                / bbt_pkg::BANK_SPAN;
    upper_tag = block_tag / bbt_pkg::BANKS;
    tag_w     = (tag_bits_q > bbt_pkg::SHIFT_W'(bbt_pkg::TAG_W)) ?
                bbt_pkg::SHIFT_W'(bbt_pkg::TAG_W) : tag_bits_q;
    tag_mask  = ((bbt_pkg::TAG_W+1)'(1) << tag_w) - (bbt_pkg::TAG_W+1)'(1);
    set_in    = bbt_pkg::SET_W'((block_pc / bbt_pkg::BANKS) % bbt_pkg::SETS);
  end

  // bank and set of the current probe
  logic [bbt_pkg::BANK_W:0]    bank_sum;
  logic                        wrap;
  logic [bbt_pkg::BANK_W-1:0]  bank_cur;
  logic [bbt_pkg::SET_W-1:0]   set_cur;
  logic [bbt_pkg::ROW_W-1:0]   row_cur;

  always_comb begin
    bank_sum = {1'b0, bank_q} + {1'b0, off_q};
    wrap     = bank_sum >= (bbt_pkg::BANK_W+1)'(bbt_pkg::BANKS);
    bank_cur = wrap ? bbt_pkg::BANK_W'(bank_sum - (bbt_pkg::BANK_W+1)'(bbt_pkg::BANKS))
                    : bbt_pkg::BANK_W'(bank_sum);
    set_cur  = wrap ? next_set_q : set_q;
    row_cur  = bbt_pkg::ROW_W'(bbt_pkg::ROW_W'(bank_cur) * bbt_pkg::ROW_W'(bbt_pkg::SETS)
               + bbt_pkg::ROW_W'(set_cur));
  end

  // memories
  logic                        meta_we;
  logic [bbt_pkg::ROW_W-1:0]   meta_waddr;
  bbt_pkg::meta_row_t          meta_wdata;
  bbt_pkg::meta_row_t          meta_rdata;
  logic                        data_we;
  bbt_pkg::data_row_t          data_wdata;
  bbt_pkg::data_row_t          data_rdata;
  logic                        rd_en;
  bbt_pkg::sel_t               sel;

  bbt_row_ram #(
    .WIDTH ($bits(bbt_pkg::meta_row_t)),
    .DEPTH (bbt_pkg::ROWS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (rd_en),
    .raddr_i (row_cur),
    .rdata_o (meta_rdata)
  );

  bbt_row_ram #(
    .WIDTH ($bits(bbt_pkg::data_row_t)),
    .DEPTH (bbt_pkg::ROWS)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (row_cur),
    .wdata_i (data_wdata),
    .re_i    (rd_en),
    .raddr_i (row_cur),
    .rdata_o (data_rdata)
  );

  bbt_way_sel u_way_sel (
    .mode_i (mode_q),
    .tag_i  (tag_q),
    .meta_i (meta_rdata),
    .data_i (data_rdata),
    .sel_o  (sel)
  );

  logic out_free;
  logic probe_done;
  logic probe_last;

  assign out_free   = !out_valid_q || out_ready_i;
  assign probe_last = off_q == bbt_pkg::BANK_W'(bbt_pkg::BANKS - 1);
  assign probe_done = (state_q == ST_EVAL) && (mode_q || out_free);
  assign rd_en      = state_q == ST_READ;
  assign in_ready_o = state_q == ST_IDLE;

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = row_cur;
    meta_wdata = '{valid: sel.valid_next, plru: sel.plru_next};
    data_we    = 1'b0;
    data_wdata = data_rdata;
    data_wdata[sel.way] = '{tag: tag_q, target: target_q};
    if (state_q == ST_CLEAR) begin
      meta_we    = 1'b1;
      meta_waddr = clr_q;
      meta_wdata = '0;
    end else if (probe_done) begin
      meta_we = mode_q || sel.hit;
      data_we = mode_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == bbt_pkg::ROW_W'(bbt_pkg::ROWS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_READ;
      ST_READ:  state_d = ST_EVAL;
      ST_EVAL: begin
        if (probe_done) state_d = (mode_q || probe_last) ? ST_IDLE : ST_READ;
      end
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      off_q       <= '0;
      pc_shift_q  <= bbt_pkg::SHIFT_W'(1);
      tag_bits_q  <= bbt_pkg::SHIFT_W'(16);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + bbt_pkg::ROW_W'(1);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bbt_pkg::REG_PC_SHIFT: pc_shift_q <= cfg_data_i;
          bbt_pkg::REG_TAG_BITS: tag_bits_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) off_q <= '0;
      else if (probe_done && !mode_q) off_q <= off_q + bbt_pkg::BANK_W'(1);
      if (probe_done && !mode_q) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q     <= mode_i;
      bank_q     <= bbt_pkg::BANK_W'(block_pc % bbt_pkg::BANKS);
      set_q      <= set_in;
      next_set_q <= (set_in == bbt_pkg::SET_W'(bbt_pkg::SETS - 1)) ? '0
                    : set_in + bbt_pkg::SET_W'(1);
      tag_q      <= upper_tag[bbt_pkg::TAG_W-1:0] & tag_mask[bbt_pkg::TAG_W-1:0];
      target_q   <= target_i;
    end
    if (probe_done && !mode_q) begin
      out_off_q    <= 3'(off_q);
      out_hit_q    <= sel.hit;
      out_target_q <= sel.target;
      out_last_q   <= probe_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bank_rel_o     = out_off_q;
  assign hit_o          = out_hit_q;
  assign found_target_o = out_target_q;
  assign last_o         = out_last_q;

endmodule
